@@ src/dvrt_pkg.sv @@
// ----------------------------------------------------------------------------
// dvrt_pkg
// Types and constants for the distance-vector route table engine.
// ----------------------------------------------------------------------------
package dvrt_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam logic [31:0] PORT_COUNT      = 32'd16;

	// item kinds on s_tuser
	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_MERGE  = 2'd2;
	localparam logic [1:0] MODE_LOOKUP = 2'd3;

	// result status on m_tuser
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOROUTE = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_SKIP    = 3'd3;
	localparam logic [2:0] ST_UPDATED = 3'd4;

	localparam logic [47:0] BCAST_MAC = 48'hffff_ffff_ffff;

	localparam int unsigned S_TDATA_W = 224;
	localparam int unsigned M_TDATA_W = 56;

	typedef struct packed {
		logic [31:0] prefix;
		logic [31:0] mask;
		logic [47:0] hop_mac;
		logic [3:0]  port;
		logic [7:0]  distance;
	} entry_t;

endpackage

@@ src/distance_vector_route_table.sv @@
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Route table with clear, direct add, advertised-route merge and
// longest-mask lookup, scanned one entry per cycle.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser: mode, s_tdata: route fields
//  m_*     | out | m_tvalid/m_tready  | m_tuser: status, m_tdata: hop, port
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: infinity_distance
//
//  Clear, add and skipped merges go from accept straight to the finish step.
//  Merge and lookup first scan the entries: one table read per cycle
//  through the single read port, one compare unit shared by all entries.
//  s_tready is high only while the sequencer is idle; a result waiting in
//  the output register does not hold off the next item.
//  Reset clears the entry count and sets infinity_distance to 16; no clearing pass.
// ----------------------------------------------------------------------------
module distance_vector_route_table #(
	parameter int unsigned TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] ip_addr, [63:32] ip_mask, [111:64] neighbor_mac,
	// [159:112] listed_mac, [207:160] local_mac, [211:208] route_port,
	// [219:212] adv_distance, [223:220] zero
	input  logic [dvrt_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [47:0] next_hop_mac, [51:48] out_port, [55:52] zero
	output logic [dvrt_pkg::M_TDATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [2:0]                     m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [7:0]                     cfg_data
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IW = $clog2(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DRAIN, S_FINISH, S_DONE
	} state_t;

	state_t state_q;

	// input fields
	logic [31:0] in_addr, in_mask;
	logic [47:0] in_nbr, in_listed, in_local;
	logic [3:0]  in_port;
	logic [7:0]  in_adv;
	logic [8:0]  in_nd;
	logic        port_bad, merge_skip;

	assign in_addr   = s_tdata[31:0];
	assign in_mask   = s_tdata[63:32];
	assign in_nbr    = s_tdata[111:64];
	assign in_listed = s_tdata[159:112];
	assign in_local  = s_tdata[207:160];
	assign in_port   = s_tdata[211:208];
	assign in_adv    = s_tdata[219:212];

	logic [7:0] inf_q;

	assign in_nd      = {1'b0, in_adv} + 9'd1;
	assign port_bad   = {28'd0, in_port} >= dvrt_pkg::PORT_COUNT;
	assign merge_skip = port_bad || (in_listed == in_local) || (in_nd >= {1'b0, inf_q});

	// latched item
	logic [1:0]  mode_q;
	logic [31:0] addr_q, mask_q;
	logic [47:0] nbr_q;
	logic [3:0]  port_q;
	logic [7:0]  nd_q;
	logic        skip_q;

	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;

	// scan results
	logic        hit_q, found_q, changed_q;
	logic [31:0] bmask_q;
	logic [47:0] bhop_q;
	logic [3:0]  bport_q;

	logic [2:0]  res_status_q;
	logic [47:0] res_hop_q;
	logic [3:0]  res_port_q;

	logic        m_tvalid_q;
	logic [2:0]  m_status_q;
	logic [47:0] m_hop_q;
	logic [3:0]  m_port_q;

	// table memory, one read and one write port
	dvrt_pkg::entry_t table_q [TABLE_DEPTH];
	dvrt_pkg::entry_t rd_entry_s1;
	logic             rd_valid_s1;
	logic [IW-1:0]    rd_idx_s1;

	logic             wr_en;
	logic [IW-1:0]    wr_idx;
	dvrt_pkg::entry_t wr_data;

	logic          accept, full, last_issue, lk_match, lk_better, mg_eq, mg_upd, do_append;
	logic [CW-1:0] count_m1;

	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign full       = (count_q == CW'(TABLE_DEPTH));
	assign count_m1   = count_q - CW'(1);
	assign last_issue = (CW'(idx_q) == count_m1);

	// shared compare unit, one entry per cycle
	assign lk_match  = ((addr_q & rd_entry_s1.mask) == rd_entry_s1.prefix);
	assign lk_better = lk_match && (!hit_q || (rd_entry_s1.mask > bmask_q));
	assign mg_eq     = (rd_entry_s1.prefix == addr_q) && (rd_entry_s1.mask == mask_q);
	assign mg_upd    = rd_valid_s1 && (mode_q == dvrt_pkg::MODE_MERGE) && mg_eq
		&& (nd_q < rd_entry_s1.distance);

	assign do_append = (state_q == S_FINISH) && !skip_q && !full
		&& ((mode_q == dvrt_pkg::MODE_ADD)
		|| ((mode_q == dvrt_pkg::MODE_MERGE) && !found_q));

	always_comb begin
		wr_en   = mg_upd || do_append;
		wr_idx  = do_append ? count_q[IW-1:0] : rd_idx_s1;
		wr_data = rd_entry_s1;
		if (do_append) begin
			wr_data.prefix   = addr_q;
			wr_data.mask     = mask_q;
			wr_data.hop_mac  = (mode_q == dvrt_pkg::MODE_ADD) ? dvrt_pkg::BCAST_MAC : nbr_q;
			wr_data.port     = port_q;
			wr_data.distance = (mode_q == dvrt_pkg::MODE_ADD) ? 8'd0 : nd_q;
		end else begin
			wr_data.hop_mac  = nbr_q;
			wr_data.port     = port_q;
			wr_data.distance = nd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_idx] <= wr_data;
		end
		rd_entry_s1 <= table_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_q <= 8'd16;
		end else if (cfg_valid && cfg_ready) begin
			inf_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// in S_DONE the output register is reloaded instead
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			// scan evaluation, runs whenever a read returns
			if (rd_valid_s1) begin
				if (mode_q == dvrt_pkg::MODE_LOOKUP) begin
					if (lk_better) begin
						hit_q   <= 1'b1;
						bmask_q <= rd_entry_s1.mask;
						bhop_q  <= rd_entry_s1.hop_mac;
						bport_q <= rd_entry_s1.port;
					end
				end else begin
					if (mg_eq) begin
						found_q <= 1'b1;
					end
					if (mg_upd) begin
						changed_q <= 1'b1;
					end
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q    <= s_tuser;
						addr_q    <= in_addr;
						mask_q    <= in_mask;
						nbr_q     <= in_nbr;
						port_q    <= in_port;
						nd_q      <= in_nd[7:0];
						hit_q     <= 1'b0;
						found_q   <= 1'b0;
						changed_q <= 1'b0;
						bmask_q   <= '0;
						idx_q     <= '0;
						skip_q    <= (s_tuser == dvrt_pkg::MODE_MERGE) ? merge_skip : port_bad;
						if (((s_tuser == dvrt_pkg::MODE_MERGE) && !merge_skip
							|| s_tuser == dvrt_pkg::MODE_LOOKUP) && (count_q != '0)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					rd_valid_s1 <= 1'b1;
					rd_idx_s1   <= idx_q;
					if (last_issue) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_DRAIN: begin
					// last entry is evaluated at this edge
					rd_valid_s1 <= 1'b0;
					state_q     <= S_FINISH;
				end
				S_FINISH: begin
					res_status_q <= dvrt_pkg::ST_OK;
					res_hop_q    <= '0;
					res_port_q   <= '0;
					unique case (mode_q)
						dvrt_pkg::MODE_CLEAR: begin
							count_q <= '0;
						end
						dvrt_pkg::MODE_ADD: begin
							if (skip_q) begin
								res_status_q <= dvrt_pkg::ST_SKIP;
							end else if (full) begin
								res_status_q <= dvrt_pkg::ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						dvrt_pkg::MODE_MERGE: begin
							if (skip_q) begin
								res_status_q <= dvrt_pkg::ST_SKIP;
							end else if (found_q) begin
								res_status_q <= changed_q ? dvrt_pkg::ST_UPDATED
									: dvrt_pkg::ST_SKIP;
							end else if (full) begin
								res_status_q <= dvrt_pkg::ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						dvrt_pkg::MODE_LOOKUP: begin
							if (hit_q) begin
								res_hop_q  <= bhop_q;
								res_port_q <= bport_q;
							end else begin
								res_status_q <= dvrt_pkg::ST_NOROUTE;
							end
						end
						default: begin
							res_status_q <= dvrt_pkg::ST_OK;
						end
					endcase
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_hop_q    <= res_hop_q;
						m_port_q   <= res_port_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {4'd0, m_port_q, m_hop_q};

	// ---- assertions ----
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while previous one in progress");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("table read returned outside a scan");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q == S_FINISH))
		else $error("entry count changed outside finish step");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the route table engine: a directed warm-up over
// the corner cases, then random route episodes under random back-pressure,
// every result checked against a behavioural copy of the table.
// ----------------------------------------------------------------------------
module tb;

	localparam int N_ROUTES     = dvrt_pkg::TABLE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] hop_mac;
		logic [3:0]  port;
	} reply_t;

	class route_table_tracker;
		logic [31:0] pfx [N_ROUTES];
		logic [31:0] msk [N_ROUTES];
		logic [47:0] hop [N_ROUTES];
		logic [3:0]  prt [N_ROUTES];
		logic [7:0]  hops [N_ROUTES];
		int unsigned n_routes;
		logic [7:0]  infinity;
		reply_t      pending_replies [$];
		int          errors;
		int          mode_seen [4];
		int          status_seen [8];

		function new();
			n_routes = 0;
			infinity = 8'd16;
			errors   = 0;
			foreach (mode_seen[i]) mode_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function logic [2:0] append(logic [31:0] a, logic [31:0] m, logic [47:0] h,
				logic [3:0] p, logic [7:0] d);
			if (n_routes >= N_ROUTES)
				return dvrt_pkg::ST_FULL;
			pfx[n_routes]  = a;
			msk[n_routes]  = m;
			hop[n_routes]  = h;
			prt[n_routes]  = p;
			hops[n_routes] = d;
			n_routes++;
			return dvrt_pkg::ST_OK;
		endfunction

		// works out the reply to one accepted item and updates the table
		function void note_command(logic [1:0] md, logic [dvrt_pkg::S_TDATA_W-1:0] d);
			logic [31:0] addr, mask, bmask;
			logic [47:0] nbr, listed, rx_mac;
			logic [3:0]  port;
			int unsigned nd, best;
			bit          found, changed, hit;
			reply_t      r;
			addr   = d[31:0];
			mask   = d[63:32];
			nbr    = d[111:64];
			listed = d[159:112];
			rx_mac = d[207:160];
			port   = d[211:208];
			nd     = d[219:212] + 1;
			r      = '0;
			r.status = dvrt_pkg::ST_OK;
			mode_seen[md]++;
			case (md)
				dvrt_pkg::MODE_CLEAR: begin
					n_routes = 0;
				end
				dvrt_pkg::MODE_ADD: begin
					if (port >= dvrt_pkg::PORT_COUNT)
						r.status = dvrt_pkg::ST_SKIP;
					else
						r.status = append(addr, mask, dvrt_pkg::BCAST_MAC, port, 8'd0);
				end
				dvrt_pkg::MODE_MERGE: begin
					if (port >= dvrt_pkg::PORT_COUNT || listed == rx_mac || nd >= infinity) begin
						r.status = dvrt_pkg::ST_SKIP;
					end else begin
						found   = 0;
						changed = 0;
						for (int i = 0; i < n_routes; i++) begin
							if (pfx[i] == addr && msk[i] == mask) begin
								found = 1;
								if (nd < hops[i]) begin
									hops[i] = nd[7:0];
									hop[i]  = nbr;
									prt[i]  = port;
									changed = 1;
								end
							end
						end
						if (!found)
							r.status = append(addr, mask, nbr, port, nd[7:0]);
						else
							r.status = changed ? dvrt_pkg::ST_UPDATED : dvrt_pkg::ST_SKIP;
					end
				end
				default: begin
					hit   = 0;
					best  = 0;
					bmask = '0;
					for (int i = 0; i < n_routes; i++) begin
						if ((addr & msk[i]) == pfx[i] && (!hit || msk[i] > bmask)) begin
							hit   = 1;
							best  = i;
							bmask = msk[i];
						end
					end
					if (hit) begin
						r.hop_mac = hop[best];
						r.port    = prt[best];
					end else begin
						r.status = dvrt_pkg::ST_NOROUTE;
					end
				end
			endcase
			status_seen[r.status]++;
			pending_replies.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_reply(logic [2:0] st, logic [dvrt_pkg::M_TDATA_W-1:0] d);
			reply_t w;
			if (pending_replies.size() == 0) begin
				report($sformatf("result st=%0d with no item pending", st));
				return;
			end
			w = pending_replies.pop_front();
			if (st !== w.status)
				report($sformatf("status %0d, want %0d", st, w.status));
			if (d[47:0] !== w.hop_mac)
				report($sformatf("next hop %h, want %h", d[47:0], w.hop_mac));
			if (d[51:48] !== w.port)
				report($sformatf("port %0d, want %0d", d[51:48], w.port));
		endtask
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [dvrt_pkg::S_TDATA_W-1:0] s_tdata;
	logic [1:0]                     s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [dvrt_pkg::M_TDATA_W-1:0] m_tdata;
	logic [2:0]                     m_tuser;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [7:0]                     cfg_data;

	route_table_tracker routes = new();

	int n_sent      = 0;
	int n_settings  = 0;
	int tx_idle_pct = 31;
	int rx_idle_pct = 31;
	int hold_cycles = 0;
	int cycle_count = 0;

	distance_vector_route_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready = 1'b0;
				hold_cycles--;
			end else begin
				m_tready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			routes.check_reply(m_tuser, m_tdata);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	function automatic logic [47:0] rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	function automatic logic [dvrt_pkg::S_TDATA_W-1:0] route_word(logic [31:0] addr,
			logic [31:0] mask, logic [47:0] nbr, logic [47:0] listed, logic [47:0] rx_mac,
			logic [3:0] port, logic [7:0] adv);
		return {4'b0, adv, port, rx_mac, listed, nbr, mask, addr};
	endfunction

	task automatic send_cmd(logic [1:0] md, logic [dvrt_pkg::S_TDATA_W-1:0] d);
		// quiet stretch with no idling on either side
		tx_idle_pct = (n_sent >= 900 && n_sent < 1150) ? 0 : 31;
		rx_idle_pct = tx_idle_pct;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = md;
		s_tdata  = d;
		do @(posedge clk); while (!s_tready);
		routes.note_command(md, d);
		n_sent++;
	endtask

	task automatic add_route(logic [31:0] addr, logic [31:0] mask, logic [3:0] port);
		send_cmd(dvrt_pkg::MODE_ADD, route_word(addr, mask, rand_mac(), rand_mac(),
			rand_mac(), port, 8'($urandom_range(255))));
	endtask

	task automatic merge_route(logic [31:0] addr, logic [31:0] mask, logic [47:0] nbr,
			logic [47:0] listed, logic [47:0] rx_mac, logic [3:0] port, logic [7:0] adv);
		send_cmd(dvrt_pkg::MODE_MERGE, route_word(addr, mask, nbr, listed, rx_mac, port, adv));
	endtask

	task automatic lookup_addr(logic [31:0] addr);
		send_cmd(dvrt_pkg::MODE_LOOKUP, route_word(addr, $urandom, rand_mac(), rand_mac(),
			rand_mac(), 4'($urandom_range(15)), 8'($urandom_range(255))));
	endtask

	task automatic clear_table();
		send_cmd(dvrt_pkg::MODE_CLEAR, route_word($urandom, $urandom, rand_mac(), rand_mac(),
			rand_mac(), 4'($urandom_range(15)), 8'($urandom_range(255))));
	endtask

	task automatic wait_drained();
		// withdraw the last item so the block cannot take it a second time
		@(negedge clk);
		s_tvalid = 1'b0;
		while (routes.pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_infinity(logic [7:0] v);
		wait_drained();
		@(negedge clk);
		s_tvalid  = 1'b0;
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		routes.infinity = v;
		n_settings++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		logic [31:0] pool_pfx [12];
		logic [31:0] pool_msk [12];
		logic [47:0] mac_a, mac_b;
		logic [31:0] m;
		int          n_pool, k, len, episode, target;
		bit          held_once, held_twice;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = dvrt_pkg::MODE_CLEAR;
		cfg_valid = 1'b0;
		cfg_data  = 8'd16;
		held_once  = 0;
		held_twice = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, default and host routes, ties, merge outcomes
		mac_a = 48'h0200_0000_00aa;
		mac_b = 48'h0200_0000_00bb;
		lookup_addr(32'h0a00_0001);
		add_route(32'h0000_0000, 32'h0000_0000, 4'd0);
		add_route(32'hffff_ffff, 32'hffff_ffff, 4'd15);
		add_route(32'h0a00_0000, 32'hff00_0000, 4'd3);
		add_route(32'h0a00_0000, 32'hff00_0000, 4'd5);
		lookup_addr(32'hffff_ffff);
		lookup_addr(32'h0a01_0203);
		lookup_addr(32'h0102_0304);
		merge_route(32'hc0a8_0000, 32'hffff_0000, 48'h0000_1111_2222, mac_a, mac_a, 4'd7, 8'd2);
		merge_route(32'hc0a8_0000, 32'hffff_0000, 48'h0000_1111_2222, mac_b, mac_a, 4'd7, 8'd15);
		merge_route(32'hc0a8_0000, 32'hffff_0000, 48'h0000_1111_2222, mac_b, mac_a, 4'd7, 8'd14);
		merge_route(32'hc0a8_0000, 32'hffff_0000, dvrt_pkg::BCAST_MAC, mac_b, mac_a, 4'd9,
			8'd3);
		merge_route(32'hc0a8_0000, 32'hffff_0000, 48'h0, mac_b, mac_a, 4'd1, 8'd3);
		merge_route(32'hc0a8_0000, 32'hffff_0000, 48'h0, mac_b, mac_a, 4'd1, 8'd255);
		merge_route(32'h0a00_0000, 32'hff00_0000, 48'h0, mac_b, mac_a, 4'd2, 8'd0);
		lookup_addr(32'hc0a8_1234);
		clear_table();
		lookup_addr(32'hffff_ffff);
		// register extremes
		write_infinity(8'd1);
		merge_route(32'h0100_0000, 32'hff00_0000, mac_b, mac_a, mac_b, 4'd4, 8'd0);
		write_infinity(8'd255);
		merge_route(32'h0100_0000, 32'hff00_0000, mac_b, mac_a, mac_b, 4'd4, 8'd253);
		merge_route(32'h0100_0000, 32'hff00_0000, mac_a, mac_a, mac_b, 4'd6, 8'd254);
		lookup_addr(32'h01ff_ffff);
		write_infinity(8'd0);
		merge_route(32'h0200_0000, 32'hff00_0000, mac_b, mac_a, mac_b, 4'd4, 8'd0);
		write_infinity(8'd16);

		// random episodes of related routes
		target  = n_sent + RANDOM_ITEMS;
		episode = 0;
		while (n_sent < target) begin
			episode++;
			if (episode % 7 == 0) begin
				case ($urandom_range(5))
					0: write_infinity(8'd1);
					1: write_infinity(8'd2);
					2: write_infinity(8'd16);
					3: write_infinity(8'd32);
					4: write_infinity(8'd255);
					default: write_infinity(8'($urandom_range(1, 255)));
				endcase
			end else if ($urandom_range(9) == 0) begin
				wait_drained();
			end
			if (!held_once && n_sent > 400) begin
				held_once   = 1;
				hold_cycles = 400;
			end
			if (!held_twice && n_sent > 1400) begin
				held_twice  = 1;
				hold_cycles = 250;
			end
			if (episode % 9 == 4) begin
				// overfill without clearing first
				repeat (70) add_route($urandom, $urandom, 4'($urandom_range(15)));
				repeat (4) lookup_addr($urandom);
				continue;
			end
			if ($urandom_range(3) != 0)
				clear_table();
			n_pool = $urandom_range(1, 12);
			for (int i = 0; i < n_pool; i++) begin
				if ($urandom_range(7) == 0) begin
					pool_msk[i] = $urandom;
					pool_pfx[i] = $urandom;
				end else begin
					len = $urandom_range(32);
					m = (len == 0) ? 32'h0 : (32'hffff_ffff << (32 - len));
					pool_msk[i] = m;
					pool_pfx[i] = $urandom & m;
				end
			end
			repeat ($urandom_range(5, 40)) begin
				k = $urandom_range(n_pool - 1);
				len = $urandom_range(99);
				if (len < 20) begin
					add_route(pool_pfx[k], pool_msk[k], 4'($urandom_range(15)));
				end else if (len < 50) begin
					mac_a = rand_mac();
					mac_b = ($urandom_range(9) == 0) ? mac_a : rand_mac();
					merge_route(pool_pfx[k], pool_msk[k], rand_mac(), mac_a, mac_b,
						4'($urandom_range(15)),
						($urandom_range(5) == 0) ? 8'($urandom_range(255))
							: 8'($urandom_range(0, routes.infinity)));
				end else if (len < 90) begin
					if ($urandom_range(4) == 0)
						lookup_addr($urandom);
					else
						lookup_addr(pool_pfx[k] | ($urandom & ~pool_msk[k]));
				end else begin
					send_cmd(2'($urandom_range(3)), route_word($urandom, $urandom, rand_mac(),
						rand_mac(), rand_mac(), 4'($urandom_range(15)),
						8'($urandom_range(255))));
				end
			end
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		wait_drained();
		repeat (80) @(posedge clk);

		$display("items: %0d clear, %0d add, %0d merge, %0d lookup; %0d register writes",
			routes.mode_seen[dvrt_pkg::MODE_CLEAR], routes.mode_seen[dvrt_pkg::MODE_ADD],
			routes.mode_seen[dvrt_pkg::MODE_MERGE], routes.mode_seen[dvrt_pkg::MODE_LOOKUP],
			n_settings);
		$display("results: %0d ok/hit, %0d no route, %0d full, %0d skipped, %0d updated",
			routes.status_seen[dvrt_pkg::ST_OK], routes.status_seen[dvrt_pkg::ST_NOROUTE],
			routes.status_seen[dvrt_pkg::ST_FULL], routes.status_seen[dvrt_pkg::ST_SKIP],
			routes.status_seen[dvrt_pkg::ST_UPDATED]);
		if (routes.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
